// File: design/esc_rs_pkg.sv
`default_nettype none

package esc_rs_pkg;

	localparam int SPEED_W = 16;
	localparam int TIME_W = 32;
	localparam int PULSE_W = 16;
	localparam int MODE_W = 4;
	localparam int PCT_W = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 24;

	localparam int DIV_NW = 23;
	localparam int DIV_DW = 16;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSE = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FWD = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REV = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE_TIME = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_GAP_TIME = 3'd5;

	localparam logic [15:0] RST_MIN_PULSE = 16'd3200;
	localparam logic [15:0] RST_MAX_PULSE = 16'd6400;
	localparam logic [14:0] RST_MAX_FWD = 15'd2000;
	localparam logic signed [15:0] RST_MAX_REV = -16'sd2000;
	localparam logic [15:0] RST_BRAKE_TIME = 16'd120;
	localparam logic [15:0] RST_GAP_TIME = 16'd120;

	localparam logic [MODE_W-1:0] MODE_NEUTRAL = 4'd0;
	localparam logic [MODE_W-1:0] MODE_N2R_TAP = 4'd1;
	localparam logic [MODE_W-1:0] MODE_N2R_GAP = 4'd2;
	localparam logic [MODE_W-1:0] MODE_FWD_HOLD = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FWD_TAP = 4'd4;
	localparam logic [MODE_W-1:0] MODE_FWD_GAP = 4'd5;
	localparam logic [MODE_W-1:0] MODE_REV_HOLD = 4'd6;
	localparam logic [MODE_W-1:0] MODE_REV_TAP = 4'd7;
	localparam logic [MODE_W-1:0] MODE_REV_GAP = 4'd8;

	localparam logic [PCT_W-1:0] DUTY_NEUTRAL = 7'd50;
	localparam logic [PCT_W-1:0] DUTY_BRAKE_REV = 7'd40;
	localparam logic [PCT_W-1:0] DUTY_BRAKE_FWD = 7'd60;
	localparam logic [PCT_W-1:0] DUTY_FULL = 7'd100;
	localparam logic [PCT_W-1:0] DUTY_ZERO = 7'd0;
	localparam logic [5:0] HALF_SCALE = 6'd50;
	localparam logic [DIV_DW-1:0] PCT_DIVISOR = 16'd100;

endpackage

`default_nettype wire

// File: design/esc_reversal_sequencer_core.sv
// A tick that writes the compare value passes the tick, multiply, divide and done states,
// a tick without a write goes from tick to done; a speed command goes from command to done,
// or through divide for a scaling division. One transaction at a time: the 23-step
// bit-serial divider and a stalled output both hold the input off. Reset is asynchronous,
// active low; all but the input, duty and output data registers reset, mode to neutral.
`default_nettype none

module esc_reversal_sequencer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [esc_rs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [esc_rs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// speed [15:0], now_ms [47:16]
	input  logic [esc_rs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// func [0]
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// pulse_ticks [15:0], pulse_written [16], motor_mode [20:17], going_forward [21]
	output logic [esc_rs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import esc_rs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMD = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;

	logic [15:0]        min_pulse_q;
	logic [15:0]        max_pulse_q;
	logic [14:0]        max_fwd_q;
	logic signed [15:0] max_rev_q;
	logic [15:0]        brake_time_q;
	logic [15:0]        gap_time_q;

	logic               func_q;
	logic signed [15:0] speed_q;
	logic [TIME_W-1:0]  now_q;

	logic [MODE_W-1:0]  mode_q;
	logic               fwd_flag_q;
	logic               target_zero_q;
	logic [PCT_W-1:0]   target_duty_q;
	logic               target_dir_q;
	logic [TIME_W-1:0]  deadline_q;
	logic [PULSE_W-1:0] last_pulse_q;
	logic               wrote_q;
	logic [PCT_W-1:0]   pct_q;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_load;

	logic [MODE_W-1:0] nxt_mode;
	logic              nxt_fwd;
	logic [TIME_W-1:0] nxt_deadline;
	logic [PCT_W-1:0]  nxt_pct;
	logic              nxt_wr;
	logic [TIME_W-1:0] diff;
	logic              reached;
	logic              same_dir;

	logic [15:0]       abs_v;
	logic              at_fwd_lim;
	logic              at_rev_lim;
	logic [15:0]       span;

	logic              div_start;
	logic [DIV_NW-1:0] div_dividend;
	logic [DIV_DW-1:0] div_divisor;
	logic [DIV_NW-1:0] div_quot;
	logic              div_done;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign abs_v = speed_q[15] ? 16'(-speed_q) : 16'(speed_q);
	assign at_fwd_lim = (speed_q >= $signed({1'b0, max_fwd_q}));
	assign at_rev_lim = (speed_q <= max_rev_q);
	assign span = (max_pulse_q >= min_pulse_q) ? (max_pulse_q - min_pulse_q) : 16'd0;

	assign diff = now_q - deadline_q;
	assign reached = !diff[TIME_W-1];
	assign same_dir = (mode_q == MODE_FWD_HOLD) ? target_dir_q : !target_dir_q;

	always_comb begin
		nxt_mode = mode_q;
		nxt_fwd = fwd_flag_q;
		nxt_deadline = deadline_q;
		nxt_pct = DUTY_NEUTRAL;
		nxt_wr = 1'b0;
		case (mode_q)
			MODE_N2R_TAP, MODE_FWD_TAP, MODE_REV_TAP: begin
				if (reached) begin
					nxt_wr = 1'b1;
					nxt_deadline = now_q + {16'd0, gap_time_q};
					nxt_mode = mode_q + 1'b1;
				end
			end
			MODE_N2R_GAP, MODE_FWD_GAP, MODE_REV_GAP: begin
				if (reached) begin
					nxt_wr = 1'b1;
					if (target_zero_q) begin
						nxt_mode = MODE_NEUTRAL;
					end else begin
						nxt_pct = target_duty_q;
						nxt_fwd = target_dir_q;
						nxt_mode = target_dir_q ? MODE_FWD_HOLD : MODE_REV_HOLD;
					end
				end
			end
			MODE_FWD_HOLD, MODE_REV_HOLD: begin
				nxt_wr = 1'b1;
				if (target_zero_q) begin
					nxt_mode = MODE_NEUTRAL;
				end else if (same_dir) begin
					nxt_pct = target_duty_q;
				end else begin
					nxt_pct = (mode_q == MODE_FWD_HOLD) ? DUTY_BRAKE_REV : DUTY_BRAKE_FWD;
					nxt_deadline = now_q + {16'd0, brake_time_q};
					nxt_mode = (mode_q == MODE_FWD_HOLD) ? MODE_FWD_TAP : MODE_REV_TAP;
				end
			end
			default: begin
				nxt_wr = 1'b1;
				nxt_mode = MODE_NEUTRAL;
				if (!target_zero_q) begin
					if (target_dir_q) begin
						nxt_pct = target_duty_q;
						nxt_fwd = 1'b1;
						nxt_mode = MODE_FWD_HOLD;
					end else begin
						nxt_pct = DUTY_BRAKE_REV;
						nxt_deadline = now_q + {16'd0, brake_time_q};
						nxt_mode = MODE_N2R_TAP;
					end
				end
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dividend = DIV_NW'(span) * DIV_NW'(pct_q);
		div_divisor = PCT_DIVISOR;
		case (state_q)
			ST_CMD: begin
				div_dividend = DIV_NW'(abs_v) * DIV_NW'(HALF_SCALE);
				div_divisor = speed_q[15] ? 16'(-max_rev_q) : {1'b0, max_fwd_q};
				div_start = (speed_q != 16'sd0) && !at_fwd_lim && !at_rev_lim;
			end
			ST_MUL: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	esc_rs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= RST_MIN_PULSE;
			max_pulse_q <= RST_MAX_PULSE;
			max_fwd_q <= RST_MAX_FWD;
			max_rev_q <= RST_MAX_REV;
			brake_time_q <= RST_BRAKE_TIME;
			gap_time_q <= RST_GAP_TIME;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MIN_PULSE: min_pulse_q <= cfg_wdata;
				CFG_MAX_PULSE: max_pulse_q <= cfg_wdata;
				CFG_MAX_FWD: max_fwd_q <= cfg_wdata[14:0];
				CFG_MAX_REV: max_rev_q <= $signed(cfg_wdata);
				CFG_BRAKE_TIME: brake_time_q <= cfg_wdata;
				CFG_GAP_TIME: gap_time_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_NEUTRAL;
			fwd_flag_q <= 1'b1;
			target_zero_q <= 1'b1;
			target_duty_q <= DUTY_NEUTRAL;
			target_dir_q <= 1'b1;
			deadline_q <= '0;
			last_pulse_q <= '0;
			wrote_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						wrote_q <= 1'b0;
						state_q <= s_axis_tuser ? ST_TICK : ST_CMD;
					end
				end
				ST_CMD: begin
					target_zero_q <= (speed_q == 16'sd0);
					if (speed_q == 16'sd0) begin
						target_duty_q <= DUTY_NEUTRAL;
						state_q <= ST_DONE;
					end else begin
						target_dir_q <= !speed_q[15];
						if (at_fwd_lim) begin
							target_duty_q <= DUTY_FULL;
							state_q <= ST_DONE;
						end else if (at_rev_lim) begin
							target_duty_q <= DUTY_ZERO;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_TICK: begin
					mode_q <= nxt_mode;
					fwd_flag_q <= nxt_fwd;
					deadline_q <= nxt_deadline;
					wrote_q <= nxt_wr;
					state_q <= nxt_wr ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (func_q) begin
							last_pulse_q <= min_pulse_q + div_quot[PULSE_W-1:0];
						end else if (speed_q[15]) begin
							target_duty_q <= DUTY_NEUTRAL - div_quot[PCT_W-1:0];
						end else begin
							target_duty_q <= DUTY_NEUTRAL + div_quot[PCT_W-1:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q <= s_axis_tuser;
			speed_q <= $signed(s_axis_tdata[SPEED_W-1:0]);
			now_q <= s_axis_tdata[SPEED_W+TIME_W-1:SPEED_W];
		end
		if (state_q == ST_TICK) begin
			pct_q <= nxt_pct;
		end
		if (out_load) begin
			out_data_q <= {2'b00, fwd_flag_q, mode_q, wrote_q, last_pulse_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

`default_nettype wire

// File: design/esc_rs_div.sv
`default_nettype none

module esc_rs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [esc_rs_pkg::DIV_NW-1:0] dividend,
	input  logic [esc_rs_pkg::DIV_DW-1:0] divisor,
	output logic [esc_rs_pkg::DIV_NW-1:0] quotient,
	output logic                          done
);
	import esc_rs_pkg::*;

	logic [DIV_NW-1:0]    quo_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DW:0]      rem_sh;
	logic [DIV_DW+1:0]    trial;

	// One quotient bit per cycle, restoring form.
	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_NW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_DW+1]) begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: design/esc_rs_chk.sv
`default_nettype none

module esc_rs_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [esc_rs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import esc_rs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output transaction changed while stalled.");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[20:17] <= MODE_REV_GAP) && (m_axis_tdata[23:22] == 2'b00))
		else $error("Output carries an impossible motor mode.");

	a_fwd_hold_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[20:17] == MODE_FWD_HOLD) |-> m_axis_tdata[21])
		else $error("Forward hold reported without forward direction.");

	a_rev_hold_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[20:17] == MODE_REV_HOLD) |-> !m_axis_tdata[21])
		else $error("Reverse hold reported with forward direction.");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("Output valid straight after reset.");

endmodule

bind esc_reversal_sequencer_core esc_rs_chk u_esc_rs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
